### design/ggb_pkg.sv
// ----------------------------------------------------------------------------
// ggb_pkg
// shared types and default sizes for the gabriel graph builder
// ----------------------------------------------------------------------------
package ggb_pkg;

	localparam int MAX_NODES_DEF  = 64;
	localparam int COORD_BITS_DEF = 16;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FETCH_I,
		ST_LATCH_I,
		ST_FETCH_J,
		ST_LATCH_J,
		ST_E_MUL,
		ST_E_SUM,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_PAIR,
		ST_ROW_END
	} ggb_state_t;

endpackage

### design/gabriel_graph_builder.sv
// ----------------------------------------------------------------------------
// gabriel_graph_builder
// Points are loaded one request per cycle into a point memory until a
// request flagged last_point arrives. The block then stalls its input and
// builds the neighbour row of each node in load order. In Gabriel mode a
// pair (i, j) is handled by forming the squared diameter first, then
// every stored point is streamed from the single read port of the point
// memory through one shared squaring unit, one containment test per cycle.
// In complete mode every other stored node is marked without a scan.
// Each row leaves through an output register, so the next row is already
// being built while the previous one waits downstream. Points offered
// beyond MAX_NODES are dropped and flagged on every row of that set.
// ----------------------------------------------------------------------------
module gabriel_graph_builder #(
	parameter int MAX_NODES  = ggb_pkg::MAX_NODES_DEF,
	parameter int COORD_BITS = ggb_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         graph_mode,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [COORD_BITS-1:0]        x_coord,
	input  logic [COORD_BITS-1:0]        y_coord,
	input  logic                         last_point,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [$clog2(MAX_NODES)-1:0] node_index,
	output logic [MAX_NODES-1:0]         neighbor_mask,
	output logic                         row_last,
	output logic                         overflow
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int DW    = COORD_BITS + 3;
	localparam int MW    = COORD_BITS + 2;
	localparam int SW    = 2 * MW;
	localparam int AW    = SW + 1;

	ggb_pkg::ggb_state_t state_q, state_d;

	logic [2*COORD_BITS-1:0] pt_mem [MAX_NODES];
	logic [2*COORD_BITS-1:0] rd_q;
	logic [IDX_W-1:0]        rd_addr;

	logic [COORD_BITS-1:0] xi_q, yi_q, xj_q, yj_q;
	logic [COORD_BITS-1:0] rd_x, rd_y;

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] i_q, j_q, l_q;
	logic             overflow_q;
	logic             mode_q;

	logic             in_acc;
	logic             mem_we;
	logic             i_last, j_last, l_last;
	logic             skip_pair;
	logic             mul_e;
	logic             out_free;

	logic [DW-1:0]    dx, dy, ex, ey;
	logic [MW-1:0]    op_a, op_b;
	logic [SW-1:0]    sq_a_s2, sq_b_s2;
	logic [AW-1:0]    sq_sum;
	logic [AW-1:0]    e_sum_q;
	logic             v_s1, v_s2;
	logic             blocked_q;
	logic [MAX_NODES-1:0] mask_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] node_index_q;
	logic [MAX_NODES-1:0] neighbor_mask_q;
	logic             row_last_q;
	logic             overflow_out_q;

	function automatic logic [MW-1:0] mag(input logic [DW-1:0] v);
		logic [DW-1:0] a;
		a = v[DW-1] ? (~v + DW'(1)) : v;
		return a[MW-1:0];
	endfunction

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign i_last   = (CNT_W'(i_q) + CNT_W'(1)) == cnt_q;
	assign j_last   = (CNT_W'(j_q) + CNT_W'(1)) == cnt_q;
	assign l_last   = (CNT_W'(l_q) + CNT_W'(1)) == cnt_q;
	assign mem_we   = in_acc && (cnt_q < CNT_W'(MAX_NODES));

	assign rd_x = rd_q[COORD_BITS-1:0];
	assign rd_y = rd_q[2*COORD_BITS-1:COORD_BITS];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ggb_pkg::ST_LOAD: begin
				if (in_acc && last_point) state_d = ggb_pkg::ST_FETCH_I;
			end
			ggb_pkg::ST_FETCH_I: state_d = ggb_pkg::ST_LATCH_I;
			ggb_pkg::ST_LATCH_I: state_d = ggb_pkg::ST_FETCH_J;
			ggb_pkg::ST_FETCH_J: begin
				if (skip_pair) begin
					state_d = j_last ? ggb_pkg::ST_ROW_END : ggb_pkg::ST_FETCH_J;
				end else begin
					state_d = ggb_pkg::ST_LATCH_J;
				end
			end
			ggb_pkg::ST_LATCH_J: state_d = ggb_pkg::ST_E_MUL;
			ggb_pkg::ST_E_MUL:   state_d = ggb_pkg::ST_E_SUM;
			ggb_pkg::ST_E_SUM:   state_d = ggb_pkg::ST_SCAN;
			ggb_pkg::ST_SCAN: begin
				if (l_last) state_d = ggb_pkg::ST_DRAIN1;
			end
			ggb_pkg::ST_DRAIN1: state_d = ggb_pkg::ST_DRAIN2;
			ggb_pkg::ST_DRAIN2: state_d = ggb_pkg::ST_PAIR;
			ggb_pkg::ST_PAIR: begin
				state_d = j_last ? ggb_pkg::ST_ROW_END : ggb_pkg::ST_FETCH_J;
			end
			ggb_pkg::ST_ROW_END: begin
				if (out_free) state_d = i_last ? ggb_pkg::ST_LOAD : ggb_pkg::ST_FETCH_I;
			end
			default: state_d = ggb_pkg::ST_LOAD;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = (state_q != ggb_pkg::ST_LOAD);
		cfg_ready = 1'b1;
		mul_e     = (state_q == ggb_pkg::ST_E_MUL);
		skip_pair = (j_q == i_q) || mode_q;
		unique case (state_q)
			ggb_pkg::ST_FETCH_I: rd_addr = i_q;
			ggb_pkg::ST_FETCH_J: rd_addr = j_q;
			default:             rd_addr = l_q;
		endcase
	end

	// shared squaring unit
	assign dx = DW'(xi_q) + DW'(xj_q) - (DW'(rd_x) << 1);
	assign dy = DW'(yi_q) + DW'(yj_q) - (DW'(rd_y) << 1);
	assign ex = DW'(xi_q) - DW'(xj_q);
	assign ey = DW'(yi_q) - DW'(yj_q);
	assign op_a = mul_e ? mag(ex) : mag(dx);
	assign op_b = mul_e ? mag(ey) : mag(dy);
	assign sq_sum = AW'(sq_a_s2) + AW'(sq_b_s2);

	// point memory
	always_ff @(posedge clk) begin
		if (mem_we) pt_mem[cnt_q[IDX_W-1:0]] <= {y_coord, x_coord};
		rd_q <= pt_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ggb_pkg::ST_LOAD;
			cnt_q       <= '0;
			overflow_q  <= 1'b0;
			mode_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			l_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ggb_pkg::ST_SCAN) && (l_q != i_q) && (l_q != j_q);
			v_s2    <= v_s1;
			if (cfg_valid && cfg_ready) mode_q <= graph_mode;
			if ((state_q == ggb_pkg::ST_ROW_END) && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ggb_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (mem_we) cnt_q <= cnt_q + CNT_W'(1);
						else        overflow_q <= 1'b1;
					end
					i_q <= '0;
				end
				ggb_pkg::ST_LATCH_I: j_q <= '0;
				ggb_pkg::ST_FETCH_J: begin
					if (skip_pair && !j_last) j_q <= j_q + IDX_W'(1);
				end
				ggb_pkg::ST_E_SUM: l_q <= '0;
				ggb_pkg::ST_SCAN: begin
					if (!l_last) l_q <= l_q + IDX_W'(1);
				end
				ggb_pkg::ST_PAIR: begin
					if (!j_last) j_q <= j_q + IDX_W'(1);
				end
				ggb_pkg::ST_ROW_END: begin
					if (out_free) begin
						if (i_last) begin
							cnt_q      <= '0;
							overflow_q <= 1'b0;
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		sq_a_s2 <= SW'(op_a) * SW'(op_a);
		sq_b_s2 <= SW'(op_b) * SW'(op_b);
		if (v_s2 && (sq_sum < e_sum_q)) blocked_q <= 1'b1;
		unique case (state_q)
			ggb_pkg::ST_FETCH_I: mask_q <= '0;
			ggb_pkg::ST_LATCH_I: begin
				xi_q <= rd_x;
				yi_q <= rd_y;
			end
			ggb_pkg::ST_FETCH_J: begin
				if (mode_q && (j_q != i_q)) mask_q[j_q] <= 1'b1;
			end
			ggb_pkg::ST_LATCH_J: begin
				xj_q <= rd_x;
				yj_q <= rd_y;
			end
			ggb_pkg::ST_E_SUM: begin
				e_sum_q   <= sq_sum;
				blocked_q <= 1'b0;
			end
			ggb_pkg::ST_PAIR: begin
				if (!blocked_q) mask_q[j_q] <= 1'b1;
			end
			ggb_pkg::ST_ROW_END: begin
				if (out_free) begin
					node_index_q    <= i_q;
					neighbor_mask_q <= mask_q;
					row_last_q      <= i_last;
					overflow_out_q  <= overflow_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign node_index    = node_index_q;
	assign neighbor_mask = neighbor_mask_q;
	assign row_last      = row_last_q;
	assign overflow      = overflow_out_q;

endmodule

### design/ggb_checker.sv
// ----------------------------------------------------------------------------
// ggb_checker
// port-level checks for the gabriel graph builder, bound to the top level
// ----------------------------------------------------------------------------
module ggb_checker #(
	parameter int MAX_NODES  = ggb_pkg::MAX_NODES_DEF,
	parameter int COORD_BITS = ggb_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         last_point,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [$clog2(MAX_NODES)-1:0] node_index,
	input logic [MAX_NODES-1:0]         neighbor_mask,
	input logic                         row_last
);

	// a held row keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(neighbor_mask) &&
			$stable(node_index) && $stable(row_last))
		else $error("stalled row changed");

	// no self loops
	a_no_self: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !neighbor_mask[node_index])
		else $error("row marks its own node");

	// a last point starts the build and closes the input
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_point |=> in_stall)
		else $error("input open after last point");

	// the input stays closed while rows of the set remain
	a_rows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_last |-> in_stall)
		else $error("input open before final row");

endmodule

bind gabriel_graph_builder ggb_checker #(
	.MAX_NODES  (MAX_NODES),
	.COORD_BITS (COORD_BITS)
) u_ggb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.last_point    (last_point),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.node_index    (node_index),
	.neighbor_mask (neighbor_mask),
	.row_last      (row_last)
);

### dv/ggb_adjacency_check.sv
// ----------------------------------------------------------------------------
// ggb_adjacency_check
// Watches the point, mode and neighbour-row channels of the gabriel graph
// builder. It keeps its own copy of the point set and the graph mode. When a
// last point is accepted, it works out every neighbour row of the set. It
// then compares each row that leaves the block with the oldest row still
// waiting, field by field.
// ----------------------------------------------------------------------------
package ggb_tb_pkg;

	typedef enum bit {
		MODE_GABRIEL,
		MODE_COMPLETE
	} graph_mode_t;

endpackage

module ggb_adjacency_check #(
	parameter int NODES = ggb_pkg::MAX_NODES_DEF,
	parameter int CBITS = ggb_pkg::COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic                     graph_mode,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [CBITS-1:0]         x_coord,
	input  logic [CBITS-1:0]         y_coord,
	input  logic                     last_point,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [$clog2(NODES)-1:0] node_index,
	input  logic [NODES-1:0]         neighbor_mask,
	input  logic                     row_last,
	input  logic                     overflow,
	output int                       fail_count,
	output int                       rows_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW = $clog2(NODES);

	typedef struct {
		logic [IW-1:0]    node;
		logic [NODES-1:0] mask;
		logic             last;
		logic             ovf;
	} adj_row_t;

	logic [CBITS-1:0]        pt_x [NODES];
	logic [CBITS-1:0]        pt_y [NODES];
	int                      stored_points = 0;
	bit                      points_dropped = 1'b0;
	ggb_tb_pkg::graph_mode_t mode_q = ggb_tb_pkg::MODE_GABRIEL;
	adj_row_t                expected_rows [$];
	adj_row_t                want;
	int                      errors = 0;

	assign fail_count = errors;

	// point l strictly inside the circle on diameter i-j, scaled by four
	function automatic bit strictly_inside(int i, int j, int l);
		longint xi, yi, xj, yj, xl, yl, dx, dy, ex, ey;
		xi = pt_x[i];
		yi = pt_y[i];
		xj = pt_x[j];
		yj = pt_y[j];
		xl = pt_x[l];
		yl = pt_y[l];
		dx = xi + xj - 2 * xl;
		dy = yi + yj - 2 * yl;
		ex = xi - xj;
		ey = yi - yj;
		return (dx * dx + dy * dy) < (ex * ex + ey * ey);
	endfunction

	function automatic void predict_rows();
		logic [NODES-1:0] adj [NODES];
		bit               joined;
		adj_row_t         row;
		for (int i = 0; i < NODES; i++)
			adj[i] = '0;
		for (int i = 0; i < stored_points; i++) begin
			for (int j = i + 1; j < stored_points; j++) begin
				joined = 1'b1;
				if (mode_q == ggb_tb_pkg::MODE_GABRIEL) begin
					for (int l = 0; l < stored_points && joined; l++)
						if (l != i && l != j && strictly_inside(i, j, l))
							joined = 1'b0;
				end
				if (joined) begin
					adj[i][j] = 1'b1;
					adj[j][i] = 1'b1;
				end
			end
		end
		for (int k = 0; k < stored_points; k++) begin
			row.node = IW'(k);
			row.mask = adj[k];
			row.last = (k == stored_points - 1);
			row.ovf  = points_dropped;
			expected_rows.push_back(row);
		end
	endfunction

	task automatic check_field(string name, logic [NODES-1:0] exp_val,
		logic [NODES-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_points  = 0;
			points_dropped = 1'b0;
			mode_q         = ggb_tb_pkg::MODE_GABRIEL;
			expected_rows.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q = ggb_tb_pkg::graph_mode_t'(graph_mode);
			if (out_valid && !out_stall) begin
				if (expected_rows.size() == 0) begin
					$error("neighbour row for node %0d with none expected", node_index);
					errors++;
				end else begin
					want = expected_rows.pop_front();
					check_field("node_index", NODES'(want.node), NODES'(node_index));
					check_field("neighbor_mask", want.mask, neighbor_mask);
					check_field("row_last", NODES'(want.last), NODES'(row_last));
					check_field("overflow", NODES'(want.ovf), NODES'(overflow));
				end
			end
			if (in_valid && !in_stall) begin
				if (stored_points < NODES) begin
					pt_x[stored_points] = x_coord;
					pt_y[stored_points] = y_coord;
					stored_points++;
				end else begin
					points_dropped = 1'b1;
				end
				if (last_point) begin
					predict_rows();
					stored_points  = 0;
					points_dropped = 1'b0;
				end
			end
		end
		rows_pending = expected_rows.size();
	end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the gabriel graph builder. Directed point sets cover the
// single node, coordinate extremes, coincident points, points on and inside
// the diameter circle and both graph modes. Random sets of mixed size and
// spread follow, plus one full set and one set that overflows the point
// store. Points go in bursts with random gaps. Rows come out against random
// stalls, with one long hold-off. The adjacency checker judges every row.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD  = 400;
	localparam int ITEM_GOAL  = 230;

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_CLUSTER,
		SPREAD_CORNER
	} spread_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        graph_mode;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] x_coord;
	logic [15:0] y_coord;
	logic        last_point;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  node_index;
	logic [63:0] neighbor_mask;
	logic        row_last;
	logic        overflow;
	int          fail_count;
	int          rows_pending;

	int items_sent  = 0;
	int burst_left  = 0;
	bit long_hold_done = 1'b0;

	gabriel_graph_builder DUT (.*);

	ggb_adjacency_check adjacency_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: stretches of no stall, light stall and heavy stall
	initial begin
		int stretch;
		int kind;
		int rows_seen;
		out_stall = 1'b0;
		rows_seen = 0;
		forever begin
			stretch = $urandom_range(1, 40);
			kind    = $urandom_range(0, 2);
			repeat (stretch) begin
				@(posedge clk);
				if (out_valid && !out_stall)
					rows_seen++;
				if (!long_hold_done && rows_seen >= 40) begin
					out_stall <= 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
					long_hold_done = 1'b1;
				end
				case (kind)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	task automatic write_mode(input ggb_tb_pkg::graph_mode_t m);
		cfg_valid  <= 1'b1;
		graph_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic offer_point(input logic [15:0] px, input logic [15:0] py, input logic lp);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		x_coord    <= px;
		y_coord    <= py;
		last_point <= lp;
		do @(posedge clk); while (in_stall);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain_rows();
		in_valid   <= 1'b0;
		last_point <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] corner_value(input logic [15:0] base);
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return base;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_set(input int count, input spread_t spread);
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] base_x;
		logic [15:0] base_y;
		base_x = 16'($urandom);
		base_y = 16'($urandom);
		for (int k = 0; k < count; k++) begin
			case (spread)
				SPREAD_WIDE: begin
					px = 16'($urandom);
					py = 16'($urandom);
				end
				SPREAD_CLUSTER: begin
					px = base_x + 16'($urandom_range(0, 7));
					py = base_y + 16'($urandom_range(0, 7));
				end
				default: begin
					px = corner_value(base_x);
					py = corner_value(base_y);
				end
			endcase
			offer_point(px, py, k == count - 1);
		end
	endtask

	task automatic run_phase(input ggb_tb_pkg::graph_mode_t m, input int sets);
		int size;
		write_mode(m);
		repeat (sets) begin
			size = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			send_set(size, spread_t'($urandom_range(0, 2)));
		end
		drain_rows();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		graph_mode = 1'b0;
		in_valid   = 1'b0;
		x_coord    = '0;
		y_coord    = '0;
		last_point = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(ggb_tb_pkg::MODE_GABRIEL);
		// single node
		offer_point(16'h0000, 16'h0000, 1'b1);
		// coordinate extremes
		offer_point(16'hFFFF, 16'hFFFF, 1'b0);
		offer_point(16'h0000, 16'h0000, 1'b1);
		// coincident points
		offer_point(16'h1234, 16'h1234, 1'b0);
		offer_point(16'h1234, 16'h1234, 1'b0);
		offer_point(16'h1240, 16'h1234, 1'b1);
		// third point on the circle does not block
		offer_point(16'd0, 16'd0, 1'b0);
		offer_point(16'd10, 16'd0, 1'b0);
		offer_point(16'd5, 16'd5, 1'b1);
		// third point strictly inside blocks
		offer_point(16'd0, 16'd0, 1'b0);
		offer_point(16'd10, 16'd0, 1'b0);
		offer_point(16'd5, 16'd1, 1'b0);
		offer_point(16'hAAAA, 16'h5555, 1'b0);
		offer_point(16'h5555, 16'hAAAA, 1'b1);
		drain_rows();

		write_mode(ggb_tb_pkg::MODE_COMPLETE);
		offer_point(16'hFFFF, 16'h0000, 1'b0);
		offer_point(16'h0000, 16'hFFFF, 1'b0);
		offer_point(16'h0007, 16'h0007, 1'b0);
		offer_point(16'h8000, 16'h8000, 1'b1);
		drain_rows();

		run_phase(ggb_tb_pkg::graph_mode_t'($urandom_range(0, 1)), 6);

		// full point store in gabriel mode
		write_mode(ggb_tb_pkg::MODE_GABRIEL);
		send_set(64, SPREAD_WIDE);
		drain_rows();

		// extras beyond the store are dropped and flagged
		write_mode(ggb_tb_pkg::MODE_COMPLETE);
		send_set(64 + $urandom_range(1, 4), spread_t'($urandom_range(0, 2)));
		drain_rows();

		while (items_sent < ITEM_GOAL)
			run_phase(ggb_tb_pkg::graph_mode_t'($urandom_range(0, 1)), 5);

		repeat (20) @(posedge clk);
		if (fail_count == 0 && rows_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### gabriel_graph_builder.f
design/ggb_pkg.sv
design/gabriel_graph_builder.sv
design/ggb_checker.sv
dv/ggb_adjacency_check.sv
dv/testbench.sv
